// File: hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants for the fixed-point ALU: operation codes, status codes
// and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

    // default sizes
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int MODE_W   = 4;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] OP_ADD    = 4'd0;
    localparam logic [MODE_W-1:0] OP_SUB    = 4'd1;
    localparam logic [MODE_W-1:0] OP_MUL    = 4'd2;
    localparam logic [MODE_W-1:0] OP_DIV    = 4'd3;
    localparam logic [MODE_W-1:0] OP_GT     = 4'd4;
    localparam logic [MODE_W-1:0] OP_LT     = 4'd5;
    localparam logic [MODE_W-1:0] OP_GE     = 4'd6;
    localparam logic [MODE_W-1:0] OP_LE     = 4'd7;
    localparam logic [MODE_W-1:0] OP_EQ     = 4'd8;
    localparam logic [MODE_W-1:0] OP_NE     = 4'd9;
    localparam logic [MODE_W-1:0] OP_MIN    = 4'd10;
    localparam logic [MODE_W-1:0] OP_MAX    = 4'd11;
    localparam logic [MODE_W-1:0] OP_INC    = 4'd12;
    localparam logic [MODE_W-1:0] OP_DEC    = 4'd13;
    localparam logic [MODE_W-1:0] OP_TO_INT = 4'd14;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU: add, sub, mul, div, compares, min/max, inc/dec,
// conversion to integer, with saturation and status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one item (mode, operand_a,
//   operand_b); output channel o_valid/i_stall carries one result item
//   (result_word, compare_true, status).
//   Every item runs through the same pipeline: two entry stages (decode,
//   multiply, multiply rounding), a row of DATA_WIDTH+FRAC_BITS division
//   cells, one per quotient bit, and a final rounding stage. One item is
//   taken per cycle while o_stall is low, set by the division cell row
//   which holds one item per cell.
//   Results leave in input order.
//   When the receiver stalls, the shown result is parked in a skid
//   register and the pipeline advances one more step; o_stall then rises
//   and the whole pipeline holds until the parked item is taken.
//   Reset clears all valid flags, including the skid valid flag; no item
//   is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire [fpa_pkg::MODE_W-1:0]     i_mode,
    input  wire [DATA_WIDTH-1:0]          i_operand_a,
    input  wire [DATA_WIDTH-1:0]          i_operand_b,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [DATA_WIDTH-1:0]         o_result_word,
    output logic                          o_compare_true,
    output logic [fpa_pkg::STATUS_W-1:0]  o_status
);

    localparam int NUM_W  = DATA_WIDTH + FRAC_BITS;
    localparam int SIDE_W = DATA_WIDTH + 5;

    logic en;

    // chain wiring between cells
    logic                  c_valid [0:NUM_W];
    logic [NUM_W-1:0]      c_num   [0:NUM_W];
    logic [DATA_WIDTH-1:0] c_rem   [0:NUM_W];
    logic [NUM_W-1:0]      c_quo   [0:NUM_W];
    logic [DATA_WIDTH-1:0] c_den   [0:NUM_W];
    logic [SIDE_W-1:0]     c_side  [0:NUM_W];

    assign c_rem[0] = '0;
    assign c_quo[0] = '0;

    fpa_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .NUM_W      (NUM_W),
        .SIDE_W     (SIDE_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_valid (c_valid[0]),
        .o_side  (c_side[0]),
        .o_num   (c_num[0]),
        .o_den   (c_den[0])
    );

    // one cell per quotient bit
    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        fpa_div_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .NUM_W      (NUM_W),
            .SIDE_W     (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[k]),
            .i_num   (c_num[k]),
            .i_rem   (c_rem[k]),
            .i_quo   (c_quo[k]),
            .i_den   (c_den[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .o_num   (c_num[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_den   (c_den[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    logic                         p_valid;
    logic [DATA_WIDTH-1:0]        p_res;
    logic                         p_cmp;
    logic [fpa_pkg::STATUS_W-1:0] p_st;

    fpa_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .NUM_W      (NUM_W),
        .SIDE_W     (SIDE_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid[NUM_W]),
        .i_quo   (c_quo[NUM_W]),
        .i_rem   (c_rem[NUM_W]),
        .i_den   (c_den[NUM_W]),
        .i_side  (c_side[NUM_W]),
        .o_valid (p_valid),
        .o_res   (p_res),
        .o_cmp   (p_cmp),
        .o_st    (p_st)
    );

    // skid register on the output side
    logic                         r_sk_v;
    logic [DATA_WIDTH-1:0]        r_sk_res;
    logic                         r_sk_cmp;
    logic [fpa_pkg::STATUS_W-1:0] r_sk_st;

    assign en      = !r_sk_v;
    assign o_stall = r_sk_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (!i_stall) r_sk_v <= 1'b0;
        end else if (p_valid && i_stall) begin
            r_sk_v <= 1'b1;
        end
        if (!r_sk_v && p_valid && i_stall) begin
            r_sk_res <= p_res;
            r_sk_cmp <= p_cmp;
            r_sk_st  <= p_st;
        end
    end

    // output select
    always_comb begin
        o_valid        = r_sk_v || p_valid;
        o_result_word  = r_sk_v ? r_sk_res : p_res;
        o_compare_true = r_sk_v ? r_sk_cmp : p_cmp;
        o_status       = r_sk_v ? r_sk_st  : p_st;
    end

endmodule

`default_nettype wire

// File: hw/rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Entry stages: decode, simple operations, magnitude multiply (stage 0),
// multiply rounding and saturation (stage 1), divider operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
    parameter int NUM_W      = DATA_WIDTH + FRAC_BITS,
    parameter int SIDE_W     = DATA_WIDTH + 5
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [fpa_pkg::MODE_W-1:0]    i_mode,
    input  wire [DATA_WIDTH-1:0]         i_a,
    input  wire [DATA_WIDTH-1:0]         i_b,
    output logic                         o_valid,
    output logic [SIDE_W-1:0]            o_side,
    output logic [NUM_W-1:0]             o_num,
    output logic [DATA_WIDTH-1:0]        o_den
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH + 1;
    localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] LIMP = {{(W+2){1'b0}}, {(W-1){1'b1}}};

    // stage 0 registers
    logic                       r_v0;
    logic [fpa_pkg::MODE_W-1:0] r_mode;
    logic [W-1:0]               r_res, n_res;
    logic                       r_cmp, n_cmp;
    logic [1:0]                 r_st, n_st;
    logic                       r_neg;
    logic [2*W-1:0]             r_prod;
    logic [NUM_W-1:0]           r_num;
    logic [W-1:0]               r_den;

    logic [W-1:0] ma, mb, sum, diff, shr;
    logic         lt, gt, eq;

    // operand decode and simple operations
    always_comb begin
        ma   = i_a[W-1] ? (~i_a + W'(1)) : i_a;
        mb   = i_b[W-1] ? (~i_b + W'(1)) : i_b;
        sum  = i_a + i_b;
        diff = i_a - i_b;
        shr  = W'($signed(i_a) >>> FRAC_BITS);
        lt   = $signed(i_a) < $signed(i_b);
        gt   = $signed(i_a) > $signed(i_b);
        eq   = (i_a == i_b);
        n_res = '0;
        n_cmp = 1'b0;
        n_st  = fpa_pkg::ST_OK;
        case (i_mode)
            fpa_pkg::OP_ADD: begin
                n_res = sum;
                if ((i_a[W-1] == i_b[W-1]) && (sum[W-1] != i_a[W-1])) begin
                    n_st  = fpa_pkg::ST_OVF;
                    n_res = i_a[W-1] ? MINW : MAXW;
                end
            end
            fpa_pkg::OP_SUB: begin
                n_res = diff;
                if ((i_a[W-1] != i_b[W-1]) && (diff[W-1] != i_a[W-1])) begin
                    n_st  = fpa_pkg::ST_OVF;
                    n_res = i_a[W-1] ? MINW : MAXW;
                end
            end
            fpa_pkg::OP_MUL: n_res = '0;
            fpa_pkg::OP_DIV: begin
                if (i_b == '0) n_st = fpa_pkg::ST_DIV0;
            end
            fpa_pkg::OP_GT:  n_cmp = gt;
            fpa_pkg::OP_LT:  n_cmp = lt;
            fpa_pkg::OP_GE:  n_cmp = !lt;
            fpa_pkg::OP_LE:  n_cmp = !gt;
            fpa_pkg::OP_EQ:  n_cmp = eq;
            fpa_pkg::OP_NE:  n_cmp = !eq;
            fpa_pkg::OP_MIN: n_res = lt ? i_a : i_b;
            fpa_pkg::OP_MAX: n_res = gt ? i_a : i_b;
            fpa_pkg::OP_INC: begin
                if (i_a == MAXW) begin
                    n_st  = fpa_pkg::ST_OVF;
                    n_res = i_a;
                end else begin
                    n_res = i_a + W'(1);
                end
            end
            fpa_pkg::OP_DEC: begin
                if (i_a == MINW) begin
                    n_st  = fpa_pkg::ST_OVF;
                    n_res = i_a;
                end else begin
                    n_res = i_a - W'(1);
                end
            end
            fpa_pkg::OP_TO_INT: n_res = shr;
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
        if (i_en) begin
            r_mode <= i_mode;
            r_res  <= n_res;
            r_cmp  <= n_cmp;
            r_st   <= n_st;
            r_neg  <= i_a[W-1] ^ i_b[W-1];
            r_prod <= (2*W)'(ma) * (2*W)'(mb);
            r_num  <= {ma, {FRAC_BITS{1'b0}}};
            r_den  <= mb;
        end
    end

    // stage 1: multiply rounding (ties away from zero) and saturation
    logic [PW-1:0] psum, pq, plim;
    logic [W-1:0]  res1;
    logic [1:0]    st1;
    logic          is_div;

    always_comb begin
        psum = {1'b0, r_prod} + HALF;
        pq   = psum >> FRAC_BITS;
        plim = r_neg ? (LIMP + PW'(1)) : LIMP;
        res1 = r_res;
        st1  = r_st;
        if (r_mode == fpa_pkg::OP_MUL) begin
            if (pq > plim) begin
                st1  = fpa_pkg::ST_OVF;
                res1 = r_neg ? MINW : MAXW;
            end else begin
                res1 = r_neg ? (~pq[W-1:0] + W'(1)) : pq[W-1:0];
            end
        end
        is_div = (r_mode == fpa_pkg::OP_DIV) && (r_st != fpa_pkg::ST_DIV0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v0;
        end
        if (i_en) begin
            o_side <= {is_div, r_neg, r_cmp, st1, res1};
            o_num  <= r_num;
            o_den  <= r_den;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division step: shifts in a numerator bit, subtracts the
// divisor when it fits, appends one quotient bit; carries the item along.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_cell #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
    parameter int NUM_W      = DATA_WIDTH + fpa_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W     = DATA_WIDTH + 5
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  wire [NUM_W-1:0]       i_num,
    input  wire [DATA_WIDTH-1:0]  i_rem,
    input  wire [NUM_W-1:0]       i_quo,
    input  wire [DATA_WIDTH-1:0]  i_den,
    input  wire [SIDE_W-1:0]      i_side,
    output logic                  o_valid,
    output logic [NUM_W-1:0]      o_num,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [NUM_W-1:0]      o_quo,
    output logic [DATA_WIDTH-1:0] o_den,
    output logic [SIDE_W-1:0]     o_side
);

    logic [DATA_WIDTH:0] r2, rn;
    logic                fits;

    // trial subtract
    always_comb begin
        r2   = {i_rem, i_num[NUM_W-1]};
        fits = r2 >= {1'b0, i_den};
        rn   = fits ? (r2 - {1'b0, i_den}) : r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_num  <= {i_num[NUM_W-2:0], 1'b0};
            o_rem  <= rn[DATA_WIDTH-1:0];
            o_quo  <= {i_quo[NUM_W-2:0], fits};
            o_den  <= i_den;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Last stage: rounds and saturates the division quotient, or passes the
// result already formed upstream.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF,
    parameter int NUM_W      = DATA_WIDTH + fpa_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W     = DATA_WIDTH + 5
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire                            i_valid,
    input  wire [NUM_W-1:0]                i_quo,
    input  wire [DATA_WIDTH-1:0]           i_rem,
    input  wire [DATA_WIDTH-1:0]           i_den,
    input  wire [SIDE_W-1:0]               i_side,
    output logic                           o_valid,
    output logic [DATA_WIDTH-1:0]          o_res,
    output logic                           o_cmp,
    output logic [fpa_pkg::STATUS_W-1:0]   o_st
);

    localparam int W = DATA_WIDTH;
    localparam logic [NUM_W:0] LIMP = {{(NUM_W+2-W){1'b0}}, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MINW = {1'b1, {(W-1){1'b0}}};

    logic           is_div, neg, rnd;
    logic [NUM_W:0] q2, lim;
    logic [W-1:0]   n_res;
    logic [1:0]     n_st;

    // round half away from zero on the magnitude, then saturate
    always_comb begin
        is_div = i_side[W+4];
        neg    = i_side[W+3];
        rnd    = {i_rem, 1'b0} >= {1'b0, i_den};
        q2     = {1'b0, i_quo} + (NUM_W+1)'(rnd);
        lim    = neg ? (LIMP + (NUM_W+1)'(1)) : LIMP;
        n_res  = i_side[W-1:0];
        n_st   = i_side[W+1:W];
        if (is_div) begin
            if (q2 > lim) begin
                n_st  = fpa_pkg::ST_OVF;
                n_res = neg ? MINW : MAXW;
            end else begin
                n_st  = fpa_pkg::ST_OK;
                n_res = neg ? (~q2[W-1:0] + W'(1)) : q2[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_res <= n_res;
            o_cmp <= i_side[W+2];
            o_st  <= n_st;
        end
    end

endmodule

`default_nettype wire
